### sv/indexed_insert_remove_array_assert.svh
// Assertion macros for the indexed insert/remove array.
// Expects clk and rst_n in scope at the point of use.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH

// same-cycle implication
`define IIRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/iira_pkg.sv
// Shared types and constants for the indexed insert/remove array.
// No dependencies.
`default_nettype none

package iira_pkg;

    localparam int DEPTH       = 64;
    localparam int ELEM_BITS   = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int REQ_W       = 4;
    localparam int FIELD_IDX_W = 7;
    localparam int VAL_W       = 32;
    localparam int LEN_W       = 7;
    localparam int ST_W        = 2;
    localparam int CMP_W       = (FIELD_IDX_W > CNT_W) ? FIELD_IDX_W : CNT_W;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    typedef logic [ELEM_BITS-1:0] elem_t;
    typedef logic [VAL_W-1:0]     word_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [IDX_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET        = 4'd0,
        REQ_SET        = 4'd1,
        REQ_INSERT     = 4'd2,
        REQ_REMOVE     = 4'd3,
        REQ_PUSH_BACK  = 4'd4,
        REQ_PUSH_FRONT = 4'd5,
        REQ_POP_BACK   = 4'd6,
        REQ_POP_FRONT  = 4'd7,
        REQ_RESIZE     = 4'd8,
        REQ_CLEAR      = 4'd9
    } req_code_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]       req_type;
        logic [FIELD_IDX_W-1:0] index;
        logic [VAL_W-1:0]       elem_value;
        logic [FIELD_IDX_W-1:0] new_length;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
    } rsp_t;

endpackage

`default_nettype wire

### sv/iira_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iira_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/indexed_insert_remove_array.sv
// Top level of the indexed insert/remove array: sequencer, count and valid bits.
// Depends on iira_pkg, iira_ram and indexed_insert_remove_array_assert.svh.
//
// Usage
//   req channel (req_valid/req_ready/req) carries one request transaction:
//   get, set, insert, remove, push/pop at either end, resize or clear.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response
//   transaction per request: status, read value (get only) and new length.
//   One request is in flight at a time; req_ready is high only while idle, so
//   a new request is accepted only once the previous one has left S_FINISH.
//   States passed from request accept to response valid, ending in S_FINISH:
//     set, resize, clear, unknown, pop of last slot, errors : S_FINISH only
//     get                                                    : S_GET_WAIT
//     insert/push : S_SHIFT_RD, S_SHIFT_WR per moved element, then S_INS_WR
//     remove/pop  : S_SHIFT_RD, S_SHIFT_WR per moved element
//   Up to DEPTH-1 elements are moved; each shifted element costs a read then
//   a write through the one RAM port pair.
//   Reset: count goes to zero and every slot's valid bit clears, so slots
//   never written read as zero. The RAM itself is not swept.
//   Stall: a response waits in the output register while rsp_ready is low;
//   the next request may be accepted meanwhile but completes only once the
//   output register has been taken.
`default_nettype none

`include "indexed_insert_remove_array_assert.svh"

module indexed_insert_remove_array (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire iira_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output iira_pkg::rsp_t      rsp
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_GET_WAIT = 6'b000010,
        S_SHIFT_RD = 6'b000100,
        S_SHIFT_WR = 6'b001000,
        S_INS_WR   = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    iira_pkg::addr_t      ptr_reg, ptr_next;
    iira_pkg::addr_t      lim_reg, lim_next;
    logic                 up_reg, up_next;
    iira_pkg::elem_t      val_reg, val_next;
    iira_pkg::cnt_t       count_reg, count_next;
    iira_pkg::status_t    st_reg, st_next;
    iira_pkg::word_t      rd_reg, rd_next;
    iira_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [iira_pkg::DEPTH-1:0] vld_reg, vld_next;
    logic                 rvld_reg;

    logic                 ram_we;
    iira_pkg::addr_t      ram_waddr;
    iira_pkg::elem_t      ram_wdata;
    logic                 ram_re;
    iira_pkg::addr_t      ram_raddr;
    iira_pkg::elem_t      ram_rdata;
    iira_pkg::elem_t      rdata_m;

    iira_pkg::req_code_t  code;
    iira_pkg::cmp_t       idx_c, cnt_c, nlen_c, pos_c;
    iira_pkg::addr_t      src;

    iira_ram #(
        .WIDTH (iira_pkg::ELEM_BITS),
        .DEPTH (iira_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign code   = iira_pkg::req_code_t'(req.req_type);
    assign idx_c  = iira_pkg::cmp_t'(req.index);
    assign cnt_c  = iira_pkg::cmp_t'(count_reg);
    assign nlen_c = iira_pkg::cmp_t'(req.new_length);

    // Slot that was never written reads as zero
    assign rdata_m = rvld_reg ? ram_rdata : '0;

    // Next slot visited by the shift walk
    assign src = up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;

    // Target position for the insert/remove family
    always_comb
    begin
        case (code)
            iira_pkg::REQ_INSERT,
            iira_pkg::REQ_REMOVE:     pos_c = idx_c;
            iira_pkg::REQ_PUSH_BACK:  pos_c = cnt_c;
            iira_pkg::REQ_POP_BACK:   pos_c = cnt_c - 1'b1;
            default:                  pos_c = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        lim_next       = lim_reg;
        up_next        = up_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        st_next        = st_reg;
        rd_next        = rd_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        vld_next       = vld_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = rdata_m;
        ram_re         = 1'b0;
        ram_raddr      = src;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    st_next    = iira_pkg::ST_OK;
                    rd_next    = '0;
                    state_next = S_FINISH;
                    case (code)
                        iira_pkg::REQ_GET:
                        begin
                            if (idx_c < cnt_c)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = iira_pkg::addr_t'(req.index);
                                state_next = S_GET_WAIT;
                            end
                            else
                            begin
                                st_next = iira_pkg::ST_BAD;
                            end
                        end
                        iira_pkg::REQ_SET:
                        begin
                            if (idx_c < cnt_c)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = iira_pkg::addr_t'(req.index);
                                ram_wdata = iira_pkg::elem_t'(req.elem_value);
                            end
                            else
                            begin
                                st_next = iira_pkg::ST_BAD;
                            end
                        end
                        iira_pkg::REQ_INSERT,
                        iira_pkg::REQ_PUSH_BACK,
                        iira_pkg::REQ_PUSH_FRONT:
                        begin
                            // index checked before capacity
                            if (pos_c > cnt_c)
                            begin
                                st_next = iira_pkg::ST_BAD;
                            end
                            else if (cnt_c >= iira_pkg::DEPTH_C)
                            begin
                                st_next = iira_pkg::ST_FULL;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                ptr_next   = iira_pkg::addr_t'(count_reg);
                                lim_next   = iira_pkg::addr_t'(pos_c);
                                val_next   = iira_pkg::elem_t'(req.elem_value);
                                count_next = count_reg + 1'b1;
                                state_next = (iira_pkg::addr_t'(count_reg)
                                              != iira_pkg::addr_t'(pos_c))
                                             ? S_SHIFT_RD : S_INS_WR;
                            end
                        end
                        iira_pkg::REQ_REMOVE,
                        iira_pkg::REQ_POP_BACK,
                        iira_pkg::REQ_POP_FRONT:
                        begin
                            // empty pop falls out here: pos wraps or equals count
                            if (pos_c >= cnt_c)
                            begin
                                st_next = iira_pkg::ST_BAD;
                            end
                            else
                            begin
                                up_next    = 1'b0;
                                ptr_next   = iira_pkg::addr_t'(pos_c);
                                lim_next   = iira_pkg::addr_t'(cnt_c - 1'b1);
                                count_next = count_reg - 1'b1;
                                if (iira_pkg::addr_t'(pos_c)
                                    != iira_pkg::addr_t'(cnt_c - 1'b1))
                                begin
                                    state_next = S_SHIFT_RD;
                                end
                            end
                        end
                        iira_pkg::REQ_RESIZE:
                        begin
                            if (nlen_c > iira_pkg::DEPTH_C)
                            begin
                                st_next = iira_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = iira_pkg::cnt_t'(nlen_c);
                            end
                        end
                        iira_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unknown request: no effect, status ok
                        end
                    endcase
                end
            end

            S_GET_WAIT:
            begin
                rd_next    = iira_pkg::word_t'(rdata_m);
                state_next = S_FINISH;
            end

            S_SHIFT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_we   = 1'b1;
                ptr_next = src;
                if (src != lim_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = up_reg ? S_INS_WR : S_FINISH;
                end
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lim_reg;
                ram_wdata  = val_reg;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status     = st_reg;
                    rsp_next.read_value = rd_reg;
                    rsp_next.length     = iira_pkg::len_t'(count_reg);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        lim_reg <= lim_next;
        up_reg  <= up_next;
        val_reg <= val_next;
        st_reg  <= st_next;
        rd_reg  <= rd_next;
        rsp_reg <= rsp_next;
        if (ram_re)
        begin
            rvld_reg <= vld_reg[ram_raddr];
        end
    end

    `IIRA_ASSERT_NOW(a_count_in_range, 1'b1,
        iira_pkg::cmp_t'(count_reg) <= iira_pkg::DEPTH_C, "count above capacity")

    `IIRA_ASSERT_NOW(a_write_only_in_write_states, ram_we,
        state_reg == S_IDLE || state_reg == S_SHIFT_WR || state_reg == S_INS_WR,
        "RAM written outside a write step")

    `IIRA_ASSERT_NEXT(a_clear_zeroes_count,
        req_valid && req_ready && req.req_type == iira_pkg::REQ_CLEAR,
        count_reg == '0, "clear left a non-zero count")

    `IIRA_ASSERT_NEXT(a_finish_loads_output,
        state_reg == S_FINISH && (!rsp_valid_reg || rsp_ready),
        rsp_valid_reg && state_reg == S_IDLE, "finished result not presented")

    `IIRA_ASSERT_NOW(a_shift_walk_bounded,
        state_reg == S_SHIFT_RD || state_reg == S_SHIFT_WR,
        ptr_reg != lim_reg, "shift walk passed its limit")

endmodule

`default_nettype wire

### sim/indexed_insert_remove_array_tb.sv
// Self-checking testbench for indexed_insert_remove_array: directed and random request
// transactions checked against an in-bench array model, with random idling on both channels.
// Depends on iira_pkg and the indexed_insert_remove_array RTL.
module indexed_insert_remove_array_tb;

    // request codes the block must ignore
    localparam logic [iira_pkg::REQ_W-1:0] REQ_UNKNOWN_LO = 4'd10;
    localparam logic [iira_pkg::REQ_W-1:0] REQ_UNKNOWN_HI = 4'd15;

    localparam int RANDOM_REQS  = 400;
    localparam int DRAIN_CYCLES = 200;  // longer than the slowest transaction
    localparam int RESET_CYCLES = 10;

    logic clk                 = 1'b0;
    logic rst_n               = 1'b0;
    logic req_valid           = 1'b0;
    logic req_ready;
    iira_pkg::req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready           = 1'b0;
    iira_pkg::rsp_t rsp;

    indexed_insert_remove_array dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Array model: element store plus element count, updated once per
    // accepted request transaction.
    // ------------------------------------------------------------------
    iira_pkg::elem_t elem_model [iira_pkg::DEPTH];
    int              len_model;

    iira_pkg::req_t  pending_reqs  [$];   // stimulus not yet offered to the block
    iira_pkg::rsp_t  expected_rsps [$];   // predicted responses, oldest first

    int    total_reqs    = 0;
    int    accepted_reqs = 0;
    int    mismatches    = 0;
    bit    req_taken     = 1'b0; // request handshake seen at the last rising edge
    int    send_gap      = 0;
    int    stall_left    = 0;
    int    calm_left     = 0;    // cycles left in a stretch with no idling at all

    // Insert at pos, shifting pos..len-1 up by one. Index is checked before fullness.
    function automatic iira_pkg::status_t model_insert(int pos, iira_pkg::word_t val);
        int i;
        if (pos > len_model) return iira_pkg::ST_BAD;
        if (len_model >= iira_pkg::DEPTH) return iira_pkg::ST_FULL;
        for (i = len_model; i > pos; i--)
            elem_model[i] = elem_model[i-1];
        elem_model[pos] = iira_pkg::elem_t'(val);
        len_model++;
        return iira_pkg::ST_OK;
    endfunction

    // Remove at pos; only pos+1..len-1 move down, so the old last slot keeps
    // its stale value and shows up again if the array is regrown.
    function automatic iira_pkg::status_t model_remove(int pos);
        int i;
        if (pos >= len_model) return iira_pkg::ST_BAD;
        for (i = pos; i + 1 < len_model; i++)
            elem_model[i] = elem_model[i+1];
        len_model--;
        return iira_pkg::ST_OK;
    endfunction

    function automatic iira_pkg::rsp_t apply_array_request(iira_pkg::req_t r);
        iira_pkg::rsp_t o;
        int             idx;
        idx          = int'(r.index);
        o.status     = iira_pkg::ST_OK;
        o.read_value = '0;
        case (r.req_type)
            iira_pkg::REQ_GET:
                if (idx < len_model) o.read_value = iira_pkg::word_t'(elem_model[idx]);
                else                 o.status = iira_pkg::ST_BAD;
            iira_pkg::REQ_SET:
                if (idx < len_model) elem_model[idx] = iira_pkg::elem_t'(r.elem_value);
                else                 o.status = iira_pkg::ST_BAD;
            iira_pkg::REQ_INSERT:     o.status = model_insert(idx, r.elem_value);
            iira_pkg::REQ_REMOVE:     o.status = model_remove(idx);
            iira_pkg::REQ_PUSH_BACK:  o.status = model_insert(len_model, r.elem_value);
            iira_pkg::REQ_PUSH_FRONT: o.status = model_insert(0, r.elem_value);
            iira_pkg::REQ_POP_BACK:
                if (len_model == 0) o.status = iira_pkg::ST_BAD;
                else                o.status = model_remove(len_model - 1);
            iira_pkg::REQ_POP_FRONT:  o.status = model_remove(0);
            iira_pkg::REQ_RESIZE:
                // shrinking only drops the count; growing exposes old contents
                if (int'(r.new_length) > iira_pkg::DEPTH) o.status = iira_pkg::ST_FULL;
                else                                      len_model = int'(r.new_length);
            iira_pkg::REQ_CLEAR:      len_model = 0;
            default: ;      // unknown codes: no effect, status ok
        endcase
        o.length = iira_pkg::len_t'(len_model);
        return o;
    endfunction

    task automatic add_req(logic [iira_pkg::REQ_W-1:0] code, int idx,
                           iira_pkg::word_t val, int nlen);
        iira_pkg::req_t r;
        r.req_type   = code;
        r.index      = idx[iira_pkg::FIELD_IDX_W-1:0];
        r.elem_value = val;
        r.new_length = nlen[iira_pkg::FIELD_IDX_W-1:0];
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // Mostly short gaps, some long ones, none at all during a calm stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm_left > 0 || roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic note_mismatch(string field, logic [iira_pkg::VAL_W-1:0] want_v,
                                 logic [iira_pkg::VAL_W-1:0] got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, want_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Driver: everything changes on the falling edge. The request payload is
    // held until its transaction completes; each signal gets one assignment.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic           next_valid;
        iira_pkg::req_t next_req;
        next_valid = req_valid;
        next_req   = req;
        if (rst_n)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(199) == 0)
                calm_left = $urandom_range(800, 300);

            // request side: a free slot once the previous transaction has gone
            if (!(req_valid && !req_taken))
            begin
                if (req_valid)
                    send_gap = pick_gap();
                if (send_gap > 0)
                begin
                    send_gap--;
                    next_valid = 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_req   = pending_reqs.pop_front();
                end
                else
                begin
                    next_valid = 1'b0;
                end
            end

            // response side: back-pressure independent of rsp_valid, so stalls
            // land both on waiting responses and on idle cycles
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(99) < 25)
                    stall_left = pick_gap();
            end
        end
        req_valid <= next_valid;
        req       <= next_req;
    end

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge. Responses are
    // checked before the new prediction is queued.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        iira_pkg::rsp_t want;
        req_taken = rst_n && req_valid && req_ready;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with none expected, got status %0d value 0x%0h len %0d",
                         $time, rsp.status, rsp.read_value, rsp.length);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch("status", iira_pkg::word_t'(want.status),
                                  iira_pkg::word_t'(rsp.status));
                if (rsp.read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, rsp.read_value);
                if (rsp.length !== want.length)
                    note_mismatch("length", iira_pkg::word_t'(want.length),
                                  iira_pkg::word_t'(rsp.length));
            end
        end
        if (req_taken)
        begin
            expected_rsps.push_back(apply_array_request(req));
            accepted_reqs++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int                          i;
        int                          roll;
        int                          idx;
        int                          nlen;
        iira_pkg::word_t             val;
        logic [iira_pkg::REQ_W-1:0]  code;

        for (i = 0; i < iira_pkg::DEPTH; i++)
            elem_model[i] = '0;
        len_model = 0;

        // directed: empty-array errors first
        add_req(iira_pkg::REQ_GET,        0,   32'h0,         0);
        add_req(iira_pkg::REQ_POP_BACK,   0,   32'h0,         0);
        add_req(iira_pkg::REQ_POP_FRONT,  0,   32'h0,         0);
        add_req(iira_pkg::REQ_REMOVE,     0,   32'h0,         0);
        // build a short array through every way in
        add_req(iira_pkg::REQ_PUSH_BACK,  0,   32'hFFFF_FFFF, 0);
        add_req(iira_pkg::REQ_PUSH_FRONT, 0,   32'h0,         0);
        add_req(iira_pkg::REQ_INSERT,     1,   32'h1234_5678, 0);
        add_req(iira_pkg::REQ_INSERT,     3,   32'hA5A5_A5A5, 0);  // at the count: append
        add_req(iira_pkg::REQ_INSERT,     5,   32'h5A5A_5A5A, 0);  // past the count: bad
        add_req(iira_pkg::REQ_GET,        1,   32'h0,         0);
        add_req(iira_pkg::REQ_GET,        127, 32'h0,         0);
        add_req(iira_pkg::REQ_SET,        0,   32'hAAAA_AAAA, 0);
        add_req(iira_pkg::REQ_SET,        4,   32'h5555_5555, 0);  // index equal to count
        // remove leaves the old tail slot stale; pop and regrow to read it back
        add_req(iira_pkg::REQ_REMOVE,     1,   32'h0,         0);
        add_req(iira_pkg::REQ_POP_BACK,   0,   32'h0,         0);
        add_req(iira_pkg::REQ_RESIZE,     0,   32'h0,         4);
        add_req(iira_pkg::REQ_GET,        3,   32'h0,         0);
        // resize beyond capacity, then to exactly full
        add_req(iira_pkg::REQ_RESIZE,     0,   32'h0,         65);
        add_req(iira_pkg::REQ_RESIZE,     0,   32'h0,         127);
        add_req(iira_pkg::REQ_RESIZE,     0,   32'h0,         64);
        // full array: index checked before fullness
        add_req(iira_pkg::REQ_PUSH_BACK,  0,   32'h5555_5555, 0);
        add_req(iira_pkg::REQ_INSERT,     64,  32'h5555_5555, 0);
        add_req(iira_pkg::REQ_INSERT,     65,  32'h5555_5555, 0);
        add_req(iira_pkg::REQ_PUSH_FRONT, 0,   32'h5555_5555, 0);
        add_req(iira_pkg::REQ_GET,        63,  32'h0,         0);  // never written: zero
        add_req(iira_pkg::REQ_GET,        64,  32'h0,         0);
        add_req(iira_pkg::REQ_REMOVE,     0,   32'h0,         0);  // longest shift
        add_req(iira_pkg::REQ_POP_FRONT,  0,   32'h0,         0);
        add_req(iira_pkg::REQ_SET,        60,  32'hDEAD_BEEF, 0);
        add_req(iira_pkg::REQ_CLEAR,      0,   32'h0,         0);
        add_req(iira_pkg::REQ_GET,        0,   32'h0,         0);
        add_req(REQ_UNKNOWN_LO,           127, 32'hFFFF_FFFF, 127);
        add_req(REQ_UNKNOWN_HI,           0,   32'h0,         0);
        add_req(iira_pkg::REQ_RESIZE,     0,   32'h0,         0);

        // random: weighted towards growth so that the array stays well populated
        for (i = 0; i < RANDOM_REQS; i++)
        begin
            roll = $urandom_range(99);
            if      (roll < 18) code = iira_pkg::REQ_GET;
            else if (roll < 30) code = iira_pkg::REQ_SET;
            else if (roll < 43) code = iira_pkg::REQ_INSERT;
            else if (roll < 53) code = iira_pkg::REQ_REMOVE;
            else if (roll < 63) code = iira_pkg::REQ_PUSH_BACK;
            else if (roll < 70) code = iira_pkg::REQ_PUSH_FRONT;
            else if (roll < 76) code = iira_pkg::REQ_POP_BACK;
            else if (roll < 81) code = iira_pkg::REQ_POP_FRONT;
            else if (roll < 91) code = iira_pkg::REQ_RESIZE;
            else if (roll < 94) code = iira_pkg::REQ_CLEAR;
            else                code = iira_pkg::REQ_W'($urandom_range(REQ_UNKNOWN_HI,
                                                                       REQ_UNKNOWN_LO));

            roll = $urandom_range(99);
            if      (roll < 50) idx = $urandom_range(7);
            else if (roll < 85) idx = $urandom_range(iira_pkg::DEPTH);
            else                idx = $urandom_range(127);

            // most resizes stay small so that shifts stay short
            roll = $urandom_range(99);
            if      (roll < 55) nlen = $urandom_range(16);
            else if (roll < 80) nlen = $urandom_range(iira_pkg::DEPTH);
            else if (roll < 88) nlen = iira_pkg::DEPTH;
            else                nlen = $urandom_range(127, iira_pkg::DEPTH + 1);

            roll = $urandom_range(99);
            if      (roll < 8)  val = '0;
            else if (roll < 16) val = '1;
            else                val = $urandom();

            add_req(code, idx, val, nlen);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs)
            @(negedge clk);
        while (expected_rsps.size() > 0)
            @(negedge clk);
        // anything arriving now is an unexpected response
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: stops a hung run with an error
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
